/* rtl/sdrbv_pkg.sv */
// shared constants, types and helper functions for the stereo dac ring buffer
package sdrbv_pkg;

	localparam int RING_DEPTH  = 2048;
	localparam int PAD_SAMPLES = 4;
	localparam int DAC_BITS    = 12;

	localparam int ADDR_W = $clog2(RING_DEPTH);
	localparam int CFG_W  = 11;
	localparam int SUM_W  = CFG_W + 1;
	localparam int LEN_W  = (SUM_W > ADDR_W + 1) ? SUM_W : ADDR_W + 1;
	localparam int CNT_W  = 12;
	localparam int VOL_W  = 6;
	localparam int OUT_W  = 12;
	localparam int SAMPLE_W = 32;

	localparam logic [CFG_W-1:0] CHUNK_RESET = CFG_W'(1152);
	localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
	localparam logic [VOL_W-1:0] FULL_VOLUME = VOL_W'(32);
	localparam logic [VOL_W-1:0] VOL_RESET   = VOL_W'(16);
	localparam int VOL_SHIFT = 5;

	localparam logic [1:0] OP_PUSH     = 2'd0;
	localparam logic [1:0] OP_TICK     = 2'd1;
	localparam logic [1:0] OP_VOL_UP   = 2'd2;
	localparam logic [1:0] OP_VOL_DOWN = 2'd3;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic             sample_valid;
		logic             buffer_low;
		logic             finished;
		logic [VOL_W-1:0] volume;
	} status_t;

	// offset binary: flip the sign bit, keep the top bits
	function automatic logic [DAC_BITS-1:0] to_code(input logic [SAMPLE_W-1:0] raw);
		logic [SAMPLE_W-1:0] v;
		v = raw ^ {1'b1, {(SAMPLE_W-1){1'b0}}};
		return v[SAMPLE_W-1 -: DAC_BITS];
	endfunction

	// code * volume / 32
	function automatic logic [OUT_W-1:0] scale(input logic [DAC_BITS-1:0] code,
			input logic [VOL_W-1:0] vol);
		logic [DAC_BITS+VOL_W-1:0] p;
		p = (DAC_BITS + VOL_W)'(code) * (DAC_BITS + VOL_W)'(vol);
		p = p >> VOL_SHIFT;
		return OUT_W'(p);
	endfunction

endpackage

/* rtl/stereo_dac_ring_buffer_volume.sv */
// top level: stereo playback ring buffer with volume scaling for a 12-bit dac pair
//
// usage notes
// - input channel s_axis: one beat per command. tuser carries the op (push,
//   tick, volume up, volume down), tdata the left and right 32-bit samples,
//   tlast marks the last push of a decoder chunk
// - output channel m_axis: exactly one beat per input beat, in order. tdata
//   carries the scaled dac codes plus buffer-low, finished and volume; tuser
//   says whether the beat holds a real sample pair
// - cfg_we/cfg_wdata write the chunk length (ring length is that plus four,
//   capped at the memory depth); write it only while the block is idle
// - throughput: one beat per cycle while the receiver keeps up; every item updates the
//   control state in the cycle it is accepted, so there is no dependency stall
// - from input beat to output beat: the ring read register, then the scale
//   multiply into the output register
// - the ring read is a registered ram read issued at the accept edge
// - reset: positions and counts clear, buffer-low set, volume 16, chunk length
//   1152; ring contents are not cleared and need no clearing pass
// - receiver stall: the output register and the read stage both fill, then
//   s_axis_tready drops; nothing is dropped or repeated
module stereo_dac_ring_buffer_volume (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,       // chunk_length
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,    // [31:0] left_sample, [63:32] right_sample
	input  logic [1:0]  s_axis_tuser,    // op
	input  logic        s_axis_tlast,    // chunk_end
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,    // [11:0] left_out, [23:12] right_out,
	                                     // [24] buffer_low, [25] finished,
	                                     // [31:26] volume_level
	output logic        m_axis_tuser     // sample_valid
);

	sdrbv_pkg::mem_req_t mem_req;
	sdrbv_pkg::status_t  status;
	sdrbv_pkg::status_t  status_s1;
	logic                valid_s1, valid_s2;
	logic                s1_ready, s2_ready, accept;
	logic [sdrbv_pkg::DAC_BITS-1:0] left_code, right_code, left_rd, right_rd;
	logic [sdrbv_pkg::OUT_W-1:0]    left_s2, right_s2;
	sdrbv_pkg::status_t  status_s2;

	// two-stage flow: the read stage drains whenever the output register frees up
	assign s2_ready = !valid_s2 || m_axis_tready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s_axis_tready = s1_ready;
	assign accept = s_axis_tvalid && s1_ready;

	assign left_code  = sdrbv_pkg::to_code(s_axis_tdata[31:0]);
	assign right_code = sdrbv_pkg::to_code(s_axis_tdata[63:32]);

	sdrbv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.op        (s_axis_tuser),
		.chunk_end (s_axis_tlast),
		.mem_req   (mem_req),
		.status    (status)
	);

	// left and right rings; read data stays put until the next read
	sdrbv_ram #(
		.WIDTH (sdrbv_pkg::DAC_BITS),
		.DEPTH (sdrbv_pkg::RING_DEPTH)
	) u_left_ring (
		.clk   (clk),
		.we    (accept && mem_req.wr_en),
		.waddr (mem_req.wr_addr),
		.wdata (left_code),
		.re    (accept && mem_req.rd_en),
		.raddr (mem_req.rd_addr),
		.rdata (left_rd)
	);

	sdrbv_ram #(
		.WIDTH (sdrbv_pkg::DAC_BITS),
		.DEPTH (sdrbv_pkg::RING_DEPTH)
	) u_right_ring (
		.clk   (clk),
		.we    (accept && mem_req.wr_en),
		.waddr (mem_req.wr_addr),
		.wdata (right_code),
		.re    (accept && mem_req.rd_en),
		.raddr (mem_req.rd_addr),
		.rdata (right_rd)
	);

	// stage 1: status of the accepted item, waiting on the ring read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
	end

	// stage 2: output register with the scaled codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			status_s2 <= status_s1;
			// codes read as zero unless a sample pair went out
			left_s2  <= status_s1.sample_valid
				? sdrbv_pkg::scale(left_rd, status_s1.volume) : '0;
			right_s2 <= status_s1.sample_valid
				? sdrbv_pkg::scale(right_rd, status_s1.volume) : '0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = status_s2.sample_valid;
	assign m_axis_tdata  = {status_s2.volume, status_s2.finished, status_s2.buffer_low,
		right_s2, left_s2};

	// a beat without a sample carries zero codes
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[23:0] == '0))
		else $error("dac codes nonzero on a beat without a sample");

	// volume never leaves its range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:26] <= sdrbv_pkg::FULL_VOLUME))
		else $error("volume above full scale");

	// an item may write or read the rings, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !(mem_req.wr_en && mem_req.rd_en))
		else $error("ring write and read on one item");

	// only a tick reads the rings
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mem_req.rd_en) |-> (s_axis_tuser == sdrbv_pkg::OP_TICK))
		else $error("ring read on an item that is not a tick");

endmodule

/* rtl/sdrbv_ram.sv */
// generic single-port-write, registered-read ram
module sdrbv_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/sdrbv_ctrl.sv */
// ring positions, counts, flags, volume and chunk length register
module sdrbv_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [sdrbv_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      accept,
	input  logic [1:0]                op,
	input  logic                      chunk_end,
	output sdrbv_pkg::mem_req_t       mem_req,
	output sdrbv_pkg::status_t        status
);

	logic [sdrbv_pkg::CFG_W-1:0]  chunk_q;
	logic [sdrbv_pkg::ADDR_W-1:0] wp_q, rp_q, wp_d, rp_d, wp_eff, rp_eff;
	logic [sdrbv_pkg::CNT_W-1:0]  vis_q, pend_q, vis_d, pend_d, vis_a;
	logic                         refill_q, low_q, refill_d, low_d;
	logic [sdrbv_pkg::VOL_W-1:0]  vol_q, vol_d;
	logic [sdrbv_pkg::LEN_W-1:0]  len_sum, len, wp_inc, rp_inc;
	logic [sdrbv_pkg::CNT_W:0]    pend_sum, vis_sum;

	always_comb begin
		len_sum = sdrbv_pkg::LEN_W'(chunk_q) + sdrbv_pkg::LEN_W'(sdrbv_pkg::PAD_SAMPLES);
		len = (len_sum > sdrbv_pkg::LEN_W'(sdrbv_pkg::RING_DEPTH))
			? sdrbv_pkg::LEN_W'(sdrbv_pkg::RING_DEPTH) : len_sum;
		// a position beyond a shrunk ring restarts at zero
		wp_eff = (sdrbv_pkg::LEN_W'(wp_q) >= len) ? '0 : wp_q;
		rp_eff = (sdrbv_pkg::LEN_W'(rp_q) >= len) ? '0 : rp_q;
		wp_inc = sdrbv_pkg::LEN_W'(wp_eff) + sdrbv_pkg::LEN_W'(1);
		rp_inc = sdrbv_pkg::LEN_W'(rp_eff) + sdrbv_pkg::LEN_W'(1);
		pend_sum = {1'b0, pend_q} + (sdrbv_pkg::CNT_W + 1)'(1);
		vis_sum  = {1'b0, vis_q} + {1'b0, pend_q};

		wp_d = wp_q;
		rp_d = rp_q;
		vis_d = vis_q;
		pend_d = pend_q;
		refill_d = refill_q;
		low_d = low_q;
		vol_d = vol_q;
		vis_a = vis_q;
		mem_req = '0;
		mem_req.wr_addr = wp_eff;
		mem_req.rd_addr = rp_eff;
		status = '0;

		unique case (op)
			sdrbv_pkg::OP_PUSH: begin
				mem_req.wr_en = 1'b1;
				wp_d = (wp_inc >= len) ? '0 : wp_inc[sdrbv_pkg::ADDR_W-1:0];
				pend_d = pend_sum[sdrbv_pkg::CNT_W] ? sdrbv_pkg::COUNT_MAX
					: pend_sum[sdrbv_pkg::CNT_W-1:0];
				if (chunk_end) begin
					refill_d = 1'b1;
					low_d = 1'b0;
				end
			end
			sdrbv_pkg::OP_TICK: begin
				// commit the pending chunk first
				if (refill_q) begin
					vis_a = vis_sum[sdrbv_pkg::CNT_W] ? sdrbv_pkg::COUNT_MAX
						: vis_sum[sdrbv_pkg::CNT_W-1:0];
					pend_d = '0;
					refill_d = 1'b0;
				end
				vis_d = vis_a;
				if (vis_a != '0) begin
					if (vis_a < sdrbv_pkg::CNT_W'(sdrbv_pkg::PAD_SAMPLES)) begin
						low_d = 1'b1;
					end
					mem_req.rd_en = 1'b1;
					status.sample_valid = 1'b1;
					rp_d = (rp_inc >= len) ? '0 : rp_inc[sdrbv_pkg::ADDR_W-1:0];
					vis_d = vis_a - sdrbv_pkg::CNT_W'(1);
				end
			end
			sdrbv_pkg::OP_VOL_UP: begin
				if (vol_q < sdrbv_pkg::FULL_VOLUME) begin
					vol_d = vol_q + sdrbv_pkg::VOL_W'(1);
				end
			end
			sdrbv_pkg::OP_VOL_DOWN: begin
				if (vol_q != '0) begin
					vol_d = vol_q - sdrbv_pkg::VOL_W'(1);
				end
			end
			default: begin
			end
		endcase

		status.buffer_low = low_d;
		status.finished = (vis_d == '0);
		status.volume = vol_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= sdrbv_pkg::CHUNK_RESET;
			wp_q <= '0;
			rp_q <= '0;
			vis_q <= '0;
			pend_q <= '0;
			refill_q <= 1'b0;
			low_q <= 1'b1;
			vol_q <= sdrbv_pkg::VOL_RESET;
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			if (accept) begin
				wp_q <= wp_d;
				rp_q <= rp_d;
				vis_q <= vis_d;
				pend_q <= pend_d;
				refill_q <= refill_d;
				low_q <= low_d;
				vol_q <= vol_d;
			end
		end
	end

endmodule

/* verif/stereo_dac_ring_buffer_volume_tb.sv */
// self-checking testbench for the stereo dac ring buffer with volume control
module stereo_dac_ring_buffer_volume_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// run ends here as a failure if the stimulus or the drain never completes
	localparam int CYCLE_LIMIT = 300000;
	// push and show counters saturate here
	localparam int CNT_CAP = 4095;
	localparam int DIR_ROWS = 20;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_BEATS = 130;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one command beat on the input stream
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] left;
		logic [31:0] right;
		logic        last;
	} dac_cmd_t;

	// one status beat on the output stream
	typedef struct packed {
		logic [11:0] left_code;
		logic [11:0] right_code;
		logic        valid;
		logic        low;
		logic        empty;
		logic [5:0]  vol;
	} dac_beat_t;

	// directed row: command plus, where obvious, the beat it must produce
	typedef struct packed {
		dac_cmd_t  cmd;
		logic      typed;
		dac_beat_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;     // [31:0] left_sample, [63:32] right_sample
	logic [1:0]  s_axis_tuser = sdrbv_pkg::OP_PUSH; // op
	logic        s_axis_tlast = 1'b0;   // chunk_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [11:0] left_out, [23:12] right_out,
	                                    // [24] buffer_low, [25] finished,
	                                    // [31:26] volume_level
	logic        m_axis_tuser;          // sample_valid

	stereo_dac_ring_buffer_volume dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// ---------------------------------------------------------------
	// playback model: rings, positions, counters, flags and volume
	// ---------------------------------------------------------------
	logic [11:0] left_mem [sdrbv_pkg::RING_DEPTH];
	logic [11:0] right_mem [sdrbv_pkg::RING_DEPTH];
	bit          mem_written [sdrbv_pkg::RING_DEPTH];   // entries the stimulus has filled
	int          wr_ptr;
	int          rd_ptr;
	int          shown_cnt;                  // samples the dac may play
	int          held_cnt;                   // pushed, waiting for a commit
	bit          commit_due;
	bit          low_now;
	int          vol_now;
	int          chunk_now;

	// beats still owed by the dut, oldest first
	dac_beat_t   dac_beats_due [$];
	int          mismatches = 0;
	int          cycle_count = 0;

	// idle percentages of the sender and the receiver
	int          gap_pct = 0;
	int          stall_pct = 0;
	// volume commands lean up (0), down (1) or either way (2)
	int          vol_drift = 2;

	// directed part: extremes of the sample codes, every op, commit with a
	// trailing push, buffer-low on the last few samples, empty tick,
	// chunk end on non-push ops and a double commit before one tick
	stim_row_t directed_rows [DIR_ROWS] = '{
		// tick on an empty buffer, stray tlast ignored
		'{'{sdrbv_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b1, 1'b1, 6'd16}},
		'{'{sdrbv_pkg::OP_VOL_UP, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b1, 1'b1, 6'd17}},
		'{'{sdrbv_pkg::OP_VOL_DOWN, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b1, 1'b1, 6'd16}},
		// most negative and most positive samples, still pending
		'{'{sdrbv_pkg::OP_PUSH, 32'h8000_0000, 32'h7fff_ffff, 1'b0}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b1, 1'b1, 6'd16}},
		'{'{sdrbv_pkg::OP_PUSH, 32'h0000_0000, 32'hffff_ffff, 1'b0}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b1, 1'b1, 6'd16}},
		// chunk end clears buffer-low, nothing visible yet
		'{'{sdrbv_pkg::OP_PUSH, 32'h0010_0000, 32'hfff0_0000, 1'b1}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b0, 1'b1, 6'd16}},
		// push after the chunk end joins the same commit
		'{'{sdrbv_pkg::OP_PUSH, 32'h1234_5678, 32'h9abc_def0, 1'b0}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b0, 1'b1, 6'd16}},
		// commit of four, first pair: codes 0x000 and 0xfff at half volume
		'{'{sdrbv_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
			'{12'h000, 12'h7ff, 1'b1, 1'b0, 1'b0, 6'd16}},
		// three left before the read, so buffer-low rises
		'{'{sdrbv_pkg::OP_TICK, 32'hffff_ffff, 32'hffff_ffff, 1'b0}, 1'b1,
			'{12'h400, 12'h3ff, 1'b1, 1'b1, 1'b0, 6'd16}},
		'{'{sdrbv_pkg::OP_VOL_UP, 32'hffff_ffff, 32'h0000_0000, 1'b0}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b1, 1'b0, 6'd17}},
		'{'{sdrbv_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{sdrbv_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{sdrbv_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
			'{12'h000, 12'h000, 1'b0, 1'b1, 1'b1, 6'd17}},
		'{'{sdrbv_pkg::OP_PUSH, 32'hffff_ffff, 32'h0000_0000, 1'b1}, 1'b0, '0},
		'{'{sdrbv_pkg::OP_VOL_DOWN, 32'hdead_beef, 32'h0bad_f00d, 1'b1}, 1'b0, '0},
		// second chunk end before any tick
		'{'{sdrbv_pkg::OP_PUSH, 32'haaaa_aaaa, 32'h5555_5555, 1'b1}, 1'b0, '0},
		'{'{sdrbv_pkg::OP_TICK, 32'h5555_5555, 32'haaaa_aaaa, 1'b1}, 1'b0, '0},
		'{'{sdrbv_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{sdrbv_pkg::OP_TICK, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, '0},
		'{'{sdrbv_pkg::OP_VOL_UP, 32'h7fff_ffff, 32'h8000_0000, 1'b1}, 1'b0, '0}
	};

	// chunk lengths and idle modes of the random phases: small, zero, the
	// largest, a shrink that strands both positions, and back to reset
	int unsigned phase_chunk [RAND_PHASES] = '{4, 0, 2047, 1, 2044, 7, 300, 1152};
	idle_mode_t  phase_idle [RAND_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
		IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

	initial begin
		forever #5 clk = ~clk;
	end

	// ring length follows the chunk length, capped at the memory depth
	function automatic int ring_len();
		int len;
		len = chunk_now + sdrbv_pkg::PAD_SAMPLES;
		return (len > sdrbv_pkg::RING_DEPTH) ? sdrbv_pkg::RING_DEPTH : len;
	endfunction

	// advance the model by one accepted command, return the beat it owes
	function automatic dac_beat_t play_step(input dac_cmd_t c);
		dac_beat_t b;
		int len;
		b = '0;
		len = ring_len();
		case (c.op)
			sdrbv_pkg::OP_PUSH: begin
				if (wr_ptr >= len)
					wr_ptr = 0;
				// offset binary: top 12 bits with the sign inverted
				left_mem[wr_ptr] = {~c.left[31], c.left[30:20]};
				right_mem[wr_ptr] = {~c.right[31], c.right[30:20]};
				mem_written[wr_ptr] = 1'b1;
				wr_ptr++;
				if (wr_ptr >= len)
					wr_ptr = 0;
				held_cnt = (held_cnt + 1 > CNT_CAP) ? CNT_CAP : held_cnt + 1;
				if (c.last) begin
					commit_due = 1'b1;
					low_now = 1'b0;
				end
			end
			sdrbv_pkg::OP_TICK: begin
				// first tick after a chunk end publishes all held samples
				if (commit_due) begin
					shown_cnt = (shown_cnt + held_cnt > CNT_CAP) ? CNT_CAP
						: shown_cnt + held_cnt;
					held_cnt = 0;
					commit_due = 1'b0;
				end
				if (shown_cnt > 0) begin
					if (shown_cnt < sdrbv_pkg::PAD_SAMPLES)
						low_now = 1'b1;
					if (rd_ptr >= len)
						rd_ptr = 0;
					b.left_code = 12'((int'(left_mem[rd_ptr]) * vol_now) / 32);
					b.right_code = 12'((int'(right_mem[rd_ptr]) * vol_now) / 32);
					b.valid = 1'b1;
					rd_ptr++;
					if (rd_ptr >= len)
						rd_ptr = 0;
					shown_cnt--;
				end
			end
			sdrbv_pkg::OP_VOL_UP: begin
				if (vol_now < int'(sdrbv_pkg::FULL_VOLUME))
					vol_now++;
			end
			default: begin
				if (vol_now > 0)
					vol_now--;
			end
		endcase
		b.low = low_now;
		b.empty = (shown_cnt == 0);
		b.vol = 6'(vol_now);
		return b;
	endfunction

	// true when a tick now would play a ring entry nobody ever wrote
	function automatic bit tick_hits_blank();
		int avail;
		int pos;
		avail = commit_due ? ((shown_cnt + held_cnt > CNT_CAP) ? CNT_CAP
			: shown_cnt + held_cnt) : shown_cnt;
		pos = (rd_ptr >= ring_len()) ? 0 : rd_ptr;
		return (avail > 0) && !mem_written[pos];
	endfunction

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_SEND: begin
				gap_pct = 85;
				stall_pct = 0;
			end
			IDLE_RECV: begin
				gap_pct = 0;
				stall_pct = 85;
			end
			IDLE_BOTH: begin
				gap_pct = 27;
				stall_pct = 27;
			end
			default: begin
				gap_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// random command: mostly pushes and ticks, chunk ends now and then,
	// volume steps leaning one way so both limits get hit
	task automatic make_cmd(output dac_cmd_t c);
		logic [31:0] rails [4];
		int pick;
		rails = '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
		pick = $urandom_range(99);
		c.left = ($urandom_range(4) == 0) ? rails[$urandom_range(3)] : $urandom;
		c.right = ($urandom_range(4) == 0) ? rails[$urandom_range(3)] : $urandom;
		c.last = ($urandom_range(3) == 0);
		if (pick < 45)
			c.op = sdrbv_pkg::OP_PUSH;
		else if (pick < 85)
			c.op = sdrbv_pkg::OP_TICK;
		else if (vol_drift == 0)
			c.op = ($urandom_range(9) == 0) ? sdrbv_pkg::OP_VOL_DOWN : sdrbv_pkg::OP_VOL_UP;
		else if (vol_drift == 1)
			c.op = ($urandom_range(9) == 0) ? sdrbv_pkg::OP_VOL_UP : sdrbv_pkg::OP_VOL_DOWN;
		else
			c.op = $urandom_range(1) ? sdrbv_pkg::OP_VOL_UP : sdrbv_pkg::OP_VOL_DOWN;
		// never play an entry that was not written: push instead
		if (c.op == sdrbv_pkg::OP_TICK && tick_hits_blank())
			c.op = sdrbv_pkg::OP_PUSH;
	endtask

	// drive one command beat, with random gaps ahead of it; on the accepting
	// edge the model steps and the owed beat is queued
	task automatic send_cmd(input dac_cmd_t c, input logic typed, input dac_beat_t want);
		dac_beat_t owed;
		if ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c.right, c.left};
		s_axis_tuser <= c.op;
		s_axis_tlast <= c.last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		owed = play_step(c);
		dac_beats_due.push_back(typed ? want : owed);
	endtask

	// every command yields a beat, so an empty queue means the block is idle
	task automatic set_chunk(input logic [10:0] len);
		s_axis_tvalid <= 1'b0;
		while (dac_beats_due.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		chunk_now = len;
	endtask

	// output side: compare each beat with the oldest owed one, then pick
	// the ready for the next cycle
	always @(posedge clk) begin : out_check
		dac_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (dac_beats_due.size() == 0) begin
				$error("output beat with nothing owed: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				want = dac_beats_due.pop_front();
				if (m_axis_tdata[11:0] !== want.left_code) begin
					$error("left_out: expected %h, got %h", want.left_code,
						m_axis_tdata[11:0]);
					mismatches++;
				end
				if (m_axis_tdata[23:12] !== want.right_code) begin
					$error("right_out: expected %h, got %h", want.right_code,
						m_axis_tdata[23:12]);
					mismatches++;
				end
				if (m_axis_tuser !== want.valid) begin
					$error("sample_valid: expected %b, got %b", want.valid, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[24] !== want.low) begin
					$error("buffer_low: expected %b, got %b", want.low, m_axis_tdata[24]);
					mismatches++;
				end
				if (m_axis_tdata[25] !== want.empty) begin
					$error("finished: expected %b, got %b", want.empty, m_axis_tdata[25]);
					mismatches++;
				end
				if (m_axis_tdata[31:26] !== want.vol) begin
					$error("volume_level: expected %0d, got %0d", want.vol,
						m_axis_tdata[31:26]);
					mismatches++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		dac_cmd_t c;
		int p;
		int n;
		// model state after reset
		for (n = 0; n < sdrbv_pkg::RING_DEPTH; n++)
			mem_written[n] = 1'b0;
		wr_ptr = 0;
		rd_ptr = 0;
		shown_cnt = 0;
		held_cnt = 0;
		commit_due = 1'b0;
		low_now = 1'b1;
		vol_now = int'(sdrbv_pkg::VOL_RESET);
		chunk_now = int'(sdrbv_pkg::CHUNK_RESET);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset chunk length, no idling
		set_idle(IDLE_NONE);
		for (n = 0; n < DIR_ROWS; n++)
			send_cmd(directed_rows[n].cmd, directed_rows[n].typed, directed_rows[n].want);

		// random phases, each under its own chunk length and idle mode
		for (p = 0; p < RAND_PHASES; p++) begin
			set_chunk(11'(phase_chunk[p]));
			set_idle(phase_idle[p]);
			for (n = 0; n < PHASE_BEATS; n++) begin
				if (n % 64 == 0)
					vol_drift = $urandom_range(2);
				make_cmd(c);
				send_cmd(c, 1'b0, '0);
			end
		end

		// drain, then let the pipeline run on for strays
		s_axis_tvalid <= 1'b0;
		while (dac_beats_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
